>>> sv/vector_terminal_coord_encoder_top_defines.svh
// Assertion macros shared by the encoder RTL
`ifndef VECTOR_TERMINAL_COORD_ENCODER_TOP_DEFINES_SVH
`define VECTOR_TERMINAL_COORD_ENCODER_TOP_DEFINES_SVH

// clocked check, disabled while in reset
`define VTCE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that an event implies a condition in the following cycle
`define VTCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/vtce_pkg.sv
// Package: op codes, terminal byte codes and packet type for the encoder
package vtce_pkg;

	localparam int MAX_BYTES = 6;

	localparam logic [2:0] OP_MOVE  = 3'd0;
	localparam logic [2:0] OP_DRAW  = 3'd1;
	localparam logic [2:0] OP_ERASE = 3'd2;
	localparam logic [2:0] OP_STYLE = 3'd3;
	localparam logic [2:0] OP_OPEN  = 3'd4;
	localparam logic [2:0] OP_CLOSE = 3'd5;

	localparam logic [7:0] B_US  = 8'h1F;
	localparam logic [7:0] B_ESC = 8'h1B;
	localparam logic [7:0] B_GS  = 8'h1D;
	localparam logic [7:0] B_FF  = 8'h0C;

	localparam logic [2:0] LS_LONG  = 3'd0;
	localparam logic [2:0] LS_SHORT = 3'd1;
	localparam logic [2:0] LS_DOTDA = 3'd2;
	localparam logic [2:0] LS_DOT   = 3'd3;

	// compacted bytes of one command, cnt is 1..6
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
	} pkt_t;

	function automatic logic [7:0] style_byte(input logic [2:0] ls);
		logic [7:0] b;
		case (ls)
			LS_LONG:  b = 8'h64;
			LS_SHORT: b = 8'h63;
			LS_DOTDA: b = 8'h62;
			LS_DOT:   b = 8'h61;
			default:  b = 8'h65;
		endcase
		return b;
	endfunction

endpackage

>>> sv/vector_terminal_coord_encoder_top.sv
// Top level: vector terminal coordinate encoder
//
//  channel | dir | tdata                                  | tuser   | tlast
//  s_*     | in  | x[11:0] y[23:12] line_style[26:24]     | op[2:0] | -
//  m_*     | out | out_byte[7:0]                          | -       | last
//
// A command yields 0 to 6 output words, one per cycle while m_tready is high, set by the serializer.
// Front end takes a command per cycle while the 2-entry packet queue has room.
// Commands that yield no bytes are absorbed without entering the queue.
// m_tready low stalls only the serializer; the front keeps filling the queue.
// arst_n clears the address tracking state, queue and serializer.
module vector_terminal_coord_encoder_top import vtce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // x[11:0], y[23:12], line_style[26:24], zero pad
	input  logic [2:0]  s_tuser,  // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic        m_tlast
);

	pkt_t f_pkt, q_pkt;
	logic f_push, q_ready, q_valid, q_pop;

	vtce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.op         (s_tuser),
		.x          (s_tdata[11:0]),
		.y          (s_tdata[23:12]),
		.line_style (s_tdata[26:24]),
		.q_ready    (q_ready),
		.in_ready   (s_tready),
		.push       (f_push),
		.pkt        (f_pkt)
	);

	vtce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wr_pkt (f_pkt),
		.ready  (q_ready),
		.pop    (q_pop),
		.valid  (q_valid),
		.rd_pkt (q_pkt)
	);

	vtce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pkt     (q_pkt),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

>>> sv/vtce_front.sv
// Front end: accepts commands, tracks terminal address state, builds byte packets
module vtce_front import vtce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [2:0]  op,
	input  logic [11:0] x,
	input  logic [11:0] y,
	input  logic [2:0]  line_style,
	input  logic        q_ready,
	output logic        in_ready,
	output logic        push,
	output pkt_t        pkt
);

	logic [11:0] last_x_q, last_y_q;
	logic [4:0]  hy_q, hx_q, ly_q;
	logic [3:0]  ex_q;
	logic        trk_q;

	logic [4:0] hx, hy, lx, ly;
	logic [3:0] ex;
	logic       chg_hy, chg_ex, chg_ly, chg_hx, moved, do_draw, accept;
	logic [MAX_BYTES-1:0]      en;
	logic [MAX_BYTES-1:0][7:0] sv;
	logic [2:0] k;

	assign hx = x[11:7];
	assign hy = y[11:7];
	assign lx = x[6:2];
	assign ly = y[6:2];
	assign ex = {y[1:0], x[1:0]};

	assign chg_hy = !trk_q || (hy != hy_q);
	assign chg_ex = !trk_q || (ex != ex_q);
	assign chg_ly = ly != ly_q;
	assign chg_hx = !trk_q || (hx != hx_q);
	assign moved  = !trk_q || (x != last_x_q) || (y != last_y_q);

	assign do_draw = (op == OP_DRAW) || ((op == OP_MOVE) && moved);
	assign in_ready = q_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		sv = '0;
		en = '0;
		case (op)
			OP_MOVE, OP_DRAW: begin
				sv[0] = B_GS;
				sv[1] = {3'b001, hy};
				sv[2] = {4'b0110, ex};
				sv[3] = {3'b011, ly};
				sv[4] = {3'b001, hx};
				sv[5] = {3'b010, lx};
				en[0] = (op == OP_MOVE) && moved;
				en[1] = do_draw && chg_hy;
				en[2] = do_draw && chg_ex;
				en[3] = do_draw && (chg_ex || chg_ly || chg_hx);
				en[4] = do_draw && chg_hx;
				en[5] = do_draw;
			end
			OP_ERASE: begin
				sv[0] = B_ESC;
				sv[1] = B_FF;
				en[1:0] = 2'b11;
			end
			OP_STYLE: begin
				sv[0] = B_ESC;
				sv[1] = style_byte(line_style);
				en[1:0] = 2'b11;
			end
			OP_OPEN: begin
				sv[0] = B_GS;
				en[0] = 1'b1;
			end
			OP_CLOSE: begin
				sv[0] = B_US;
				en[0] = 1'b1;
			end
			default: begin
				en = '0;
			end
		endcase
	end

	// pack enabled slots to the front, order kept
	always_comb begin
		k = '0;
		pkt.bytes = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (en[i]) begin
				pkt.bytes[k] = sv[i];
				k = k + 3'd1;
			end
		end
		pkt.cnt = k;
	end

	assign push = accept && (k != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			hy_q     <= '0;
			hx_q     <= '0;
			ly_q     <= '0;
			ex_q     <= '0;
			trk_q    <= 1'b0;
		end else if (accept) begin
			if (do_draw) begin
				last_x_q <= x;
				last_y_q <= y;
				hy_q     <= hy;
				hx_q     <= hx;
				ly_q     <= ly;
				ex_q     <= ex;
				trk_q    <= 1'b1;
			end else if (op == OP_ERASE) begin
				trk_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/vtce_queue.sv
// Two-entry packet queue between front end and serializer
`include "vector_terminal_coord_encoder_top_defines.svh"
module vtce_queue import vtce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pkt_t wr_pkt,
	output logic ready,
	input  logic pop,
	output logic valid,
	output pkt_t rd_pkt
);

	pkt_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign ready  = cnt_q != 2'd2;
	assign valid  = cnt_q != 2'd0;
	assign rd_pkt = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`VTCE_ASSERT(a_no_overflow, push |-> (cnt_q != 2'd2), "push into full queue")
	`VTCE_ASSERT(a_no_underflow, pop |-> (cnt_q != 2'd0), "pop from empty queue")
	`VTCE_ASSERT(a_pkt_nonempty, push |-> (wr_pkt.cnt != 3'd0), "empty packet queued")

endmodule

>>> sv/vtce_back.sv
// Serializer: sends queued packets one byte per word, tlast on the final byte
`include "vector_terminal_coord_encoder_top_defines.svh"
module vtce_back import vtce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  pkt_t       q_pkt,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	pkt_t       cur_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       take, done;

	assign out_valid = busy_q;
	assign out_byte  = cur_q.bytes[idx_q];
	assign out_last  = (idx_q + 3'd1) == cur_q.cnt;
	assign take      = busy_q && out_ready;
	assign done      = take && out_last;
	assign pop       = q_valid && (!busy_q || done);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (!busy_q || done) begin
			busy_q <= q_valid;
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	`VTCE_ASSERT(a_idx_range, busy_q |-> (idx_q < cur_q.cnt), "byte index past packet end")
	`VTCE_ASSERT_NEXT(a_load_busy, pop, busy_q && (idx_q == 3'd0), "packet load did not start")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the vector terminal coordinate encoder byte stream
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vtce_pkg::*;

	localparam logic [2:0] OP_RSVD_A = 3'd6;
	localparam logic [2:0] OP_RSVD_B = 3'd7;

	localparam logic [7:0] TAG_HI    = 8'h20;
	localparam logic [7:0] TAG_EXTRA = 8'h60;
	localparam logic [7:0] TAG_LO_Y  = 8'h60;
	localparam logic [7:0] TAG_LO_X  = 8'h40;

	localparam logic [7:0] CH_LONG    = 8'h64;
	localparam logic [7:0] CH_SHORT   = 8'h63;
	localparam logic [7:0] CH_DOTDASH = 8'h62;
	localparam logic [7:0] CH_DOT     = 8'h61;
	localparam logic [7:0] CH_SOLID   = 8'h65;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 120;

	class coord_stream_board;
		logic [8:0]  due[$];   // {last, out_byte}
		logic [7:0]  burst[$];
		logic [11:0] pen_x, pen_y;
		logic [4:0]  hy_sent, hx_sent, ly_sent;
		logic [3:0]  ex_sent;
		logic        tracked;
		int          errors;

		function new();
			pen_x = '0;
			pen_y = '0;
			hy_sent = '0;
			hx_sent = '0;
			ly_sent = '0;
			ex_sent = '0;
			tracked = 1'b0;
			errors = 0;
		endfunction

		// address bytes for a vector to (x, y), only those the terminal needs
		function void plot_to(input logic [11:0] x, input logic [11:0] y);
			logic [4:0] hx, hy, lx, ly;
			logic [3:0] ex;
			hx = x[11:7];
			hy = y[11:7];
			lx = x[6:2];
			ly = y[6:2];
			ex = {y[1:0], x[1:0]};
			if (!tracked || hy != hy_sent) burst.push_back(TAG_HI | 8'(hy));
			if (!tracked || ex != ex_sent) begin
				burst.push_back(TAG_EXTRA | 8'(ex));
				burst.push_back(TAG_LO_Y | 8'(ly));
				if (!tracked || hx != hx_sent) burst.push_back(TAG_HI | 8'(hx));
			end else if (ly != ly_sent) begin
				burst.push_back(TAG_LO_Y | 8'(ly));
				if (hx != hx_sent) burst.push_back(TAG_HI | 8'(hx));
			end else if (hx != hx_sent) begin
				burst.push_back(TAG_LO_Y | 8'(ly));
				burst.push_back(TAG_HI | 8'(hx));
			end
			burst.push_back(TAG_LO_X | 8'(lx));
			hy_sent = hy;
			hx_sent = hx;
			ly_sent = ly;
			ex_sent = ex;
			pen_x = x;
			pen_y = y;
			tracked = 1'b1;
		endfunction

		function void note_command(input logic [2:0] op, input logic [11:0] x,
				input logic [11:0] y, input logic [2:0] ls);
			burst.delete();
			case (op)
				OP_MOVE: begin
					if (!tracked || x != pen_x || y != pen_y) begin
						burst.push_back(B_GS);
						plot_to(x, y);
					end
				end
				OP_DRAW: plot_to(x, y);
				OP_ERASE: begin
					burst.push_back(B_ESC);
					burst.push_back(B_FF);
					tracked = 1'b0;
				end
				OP_STYLE: begin
					burst.push_back(B_ESC);
					case (ls)
						LS_LONG:  burst.push_back(CH_LONG);
						LS_SHORT: burst.push_back(CH_SHORT);
						LS_DOTDA: burst.push_back(CH_DOTDASH);
						LS_DOT:   burst.push_back(CH_DOT);
						default:  burst.push_back(CH_SOLID);
					endcase
				end
				OP_OPEN: burst.push_back(B_GS);
				OP_CLOSE: burst.push_back(B_US);
				default: ;
			endcase
			foreach (burst[i])
				due.push_back({(i == burst.size() - 1) ? 1'b1 : 1'b0, burst[i]});
		endfunction

		function void check_word(input logic [7:0] b, input logic l);
			logic [8:0] want;
			if (due.size() == 0) begin
				$display("%0t: unexpected word, expected none, got out_byte %h last %b",
					$time, b, l);
				errors++;
			end else begin
				want = due.pop_front();
				if (want[7:0] !== b) begin
					$display("%0t: out_byte expected %h got %h", $time, want[7:0], b);
					errors++;
				end
				if (want[8] !== l) begin
					$display("%0t: last expected %b got %b", $time, want[8], l);
					errors++;
				end
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	coord_stream_board sb;
	int cycles = 0;
	int sent_items = 0;
	bit src_gaps_on = 1'b1;
	bit sink_stalls_on = 1'b1;

	vector_terminal_coord_encoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still due", $time, sb.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : sink
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (sink_stalls_on && $urandom_range(0, 99) < 35) begin
				hold = gap_len();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_cmd(input logic [2:0] op, input logic [11:0] x, input logic [11:0] y,
			input logic [2:0] ls);
		int n;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'd0, ls, y, x};
		do @(posedge clk); while (!s_tready);
		sb.note_command(op, x, y, ls);
		if (op <= OP_CLOSE) sent_items++;
		@(negedge clk);
		n = src_gaps_on ? gap_len() : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	initial begin : stimulus
		int n, k;
		logic [11:0] cx, cy;
		sb = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed
		sink_stalls_on = 1'b0;
		src_gaps_on = 1'b0;
		send_cmd(OP_OPEN, 12'd0, 12'd0, LS_LONG);
		send_cmd(OP_STYLE, 12'd0, 12'd0, LS_LONG);
		send_cmd(OP_STYLE, 12'd0, 12'd0, LS_SHORT);
		send_cmd(OP_STYLE, 12'd0, 12'd0, LS_DOTDA);
		send_cmd(OP_STYLE, 12'd0, 12'd0, LS_DOT);
		send_cmd(OP_STYLE, 12'd0, 12'd0, 3'd4);
		send_cmd(OP_STYLE, 12'd0, 12'd0, 3'd7);
		send_cmd(OP_MOVE, 12'd0, 12'd0, LS_LONG);      // nothing tracked yet
		send_cmd(OP_MOVE, 12'd0, 12'd0, LS_LONG);      // same point, no words
		send_cmd(OP_DRAW, 12'hFFF, 12'hFFF, 3'd7);
		send_cmd(OP_DRAW, 12'hFFF, 12'hFFF, 3'd7);     // low-x only
		sink_stalls_on = 1'b1;
		src_gaps_on = 1'b1;
		send_cmd(OP_DRAW, 12'h07F, 12'hFFF, 3'd0);     // high-x only
		send_cmd(OP_DRAW, 12'h07F, 12'hF83, 3'd0);     // low-y only
		send_cmd(OP_DRAW, 12'hFFF, 12'hFFF, 3'd0);     // low-y and high-x
		send_cmd(OP_DRAW, 12'hFFE, 12'hFFF, 3'd0);     // extra only
		send_cmd(OP_DRAW, 12'hFFE, 12'h07F, 3'd0);     // high-y only
		send_cmd(OP_MOVE, 12'd123, 12'd456, 3'd0);
		send_cmd(OP_ERASE, 12'hFFF, 12'hFFF, 3'd7);
		send_cmd(OP_DRAW, 12'd123, 12'd456, 3'd0);     // full address after erase
		send_cmd(OP_RSVD_A, 12'hABC, 12'h123, 3'd5);
		send_cmd(OP_RSVD_B, 12'hFFF, 12'hFFF, 3'd7);
		send_cmd(OP_STYLE, 12'd0, 12'd0, 3'd5);
		send_cmd(OP_STYLE, 12'd0, 12'd0, 3'd6);
		send_cmd(OP_CLOSE, 12'd0, 12'd0, 3'd0);
		drain();

		// random plot sessions with some noise
		while (sent_items < RANDOM_ITEMS) begin
			src_gaps_on = $urandom_range(0, 3) != 0;
			sink_stalls_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 4) == 0)
					send_cmd(OP_ERASE, 12'($urandom), 12'($urandom), 3'($urandom));
				send_cmd(OP_OPEN, 12'($urandom), 12'($urandom), 3'($urandom));
				if ($urandom_range(0, 1) == 1)
					send_cmd(OP_STYLE, 12'($urandom), 12'($urandom), 3'($urandom));
				cx = 12'($urandom);
				cy = 12'($urandom);
				send_cmd(OP_MOVE, cx, cy, 3'($urandom));
				n = $urandom_range(1, 6);
				repeat (n) begin
					k = $urandom_range(0, 9);
					case (k)
						0: cx[1:0] ^= 2'($urandom_range(1, 3));
						1: cx[6:2] ^= 5'($urandom_range(1, 31));
						2: cx[11:7] ^= 5'($urandom_range(1, 31));
						3: cy[1:0] ^= 2'($urandom_range(1, 3));
						4: cy[6:2] ^= 5'($urandom_range(1, 31));
						5: cy[11:7] ^= 5'($urandom_range(1, 31));
						6: begin
							cx[1:0] ^= 2'($urandom);
							cy[6:2] ^= 5'($urandom);
							cx[11:7] ^= 5'($urandom);
						end
						7: begin
							cx = 12'($urandom);
							cy = 12'($urandom);
						end
						default: ;
					endcase
					send_cmd(($urandom_range(0, 3) == 0) ? OP_MOVE : OP_DRAW, cx, cy,
						3'($urandom));
				end
				send_cmd(OP_CLOSE, 12'($urandom), 12'($urandom), 3'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					send_cmd(3'($urandom), 12'($urandom), 12'($urandom), 3'($urandom));
			end
			if ($urandom_range(0, 7) == 0) drain();
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+sv
sv/vtce_pkg.sv
sv/vtce_front.sv
sv/vtce_queue.sv
sv/vtce_back.sv
sv/vector_terminal_coord_encoder_top.sv
tb/sv/testbench.sv
